/* src/tlc_pkg.sv */
`timescale 1ns / 1ps
package tlc_pkg;

    localparam int TABLE_DEPTH    = 16;
    localparam int IDX_W          = $clog2(TABLE_DEPTH);
    localparam int CNT_W          = $clog2(TABLE_DEPTH + 1);
    localparam logic [31:0] CHECK_INTERVAL = 32'd5;
    localparam logic [31:0] INVALID_KEY    = 32'hFFFF_FFFF;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_CHECK  = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    localparam logic [0:0] REG_TTL = 1'b0;
    localparam logic [0:0] REG_MAX = 1'b1;

    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] key_id;
        logic [63:0] name_code;
        logic [31:0] now;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic        was_hit;
        logic [63:0] name_out;
        logic        name_changed;
        logic        maintained;
        logic [4:0]  entry_count;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
    } t_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_DECIDE,
        S_MAINT,
        S_EVICT,
        S_DONE
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic search_step;
        logic decide;
        logic maint_step;
        logic evict;
        logic finish;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_last;
        logic run_maint;
    } t_stat;

endpackage

/* src/tlc_datapath.sv */
`timescale 1ns / 1ps
module tlc_datapath (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tlc_pkg::t_cmd  i_cmd,
    output tlc_pkg::t_stat o_stat,
    input  tlc_pkg::t_in   i_item,
    input  logic [15:0]    i_ttl,
    input  logic [3:0]     i_max,
    output tlc_pkg::t_out  o_res
);
    import tlc_pkg::*;

    logic [TABLE_DEPTH-1:0] r_valid;
    logic [31:0] r_key      [TABLE_DEPTH];
    logic [63:0] r_name     [TABLE_DEPTH];
    logic [31:0] r_created  [TABLE_DEPTH];
    logic [31:0] r_accessed [TABLE_DEPTH];

    t_in          r_item;
    logic [IDX_W-1:0] r_idx;
    logic         r_found, r_free_ok;
    logic [IDX_W-1:0] r_hit_slot, r_free_slot;
    logic         r_victim_ok;
    logic [IDX_W-1:0] r_victim;
    logic [31:0]  r_victim_age;
    logic [CNT_W-1:0] r_surv;
    logic         r_run_maint;
    logic [31:0]  r_last_check, r_hits, r_misses;
    t_out         r_res;

    logic [31:0]  age_created, age_access;
    logic [CNT_W-1:0] cnt;

    assign age_created = r_item.now - r_created[r_idx];
    assign age_access  = r_item.now - r_accessed[r_idx];

    always_comb begin
        cnt = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) cnt = cnt + CNT_W'(r_valid[i]);
    end

    assign o_stat.scan_last = (r_idx == IDX_W'(TABLE_DEPTH - 1));
    assign o_stat.run_maint = r_run_maint;
    assign o_res = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid      <= '0;
            r_last_check <= '0;
            r_hits       <= '0;
            r_misses     <= '0;
            r_run_maint  <= 1'b0;
            r_idx        <= '0;
        end else begin
            if (i_cmd.load) begin
                r_item      <= i_item;
                r_idx       <= '0;
                r_found     <= 1'b0;
                r_free_ok   <= 1'b0;
                r_run_maint <= 1'b0;
                r_res       <= '0;
            end
            if (i_cmd.search_step) begin
                if (r_valid[r_idx] && r_key[r_idx] == r_item.key_id && !r_found) begin
                    r_found    <= 1'b1;
                    r_hit_slot <= r_idx;
                end
                if (!r_valid[r_idx] && !r_free_ok) begin
                    r_free_ok   <= 1'b1;
                    r_free_slot <= r_idx;
                end
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.decide) begin
                r_idx        <= '0;
                r_victim_ok  <= 1'b0;
                r_victim_age <= '0;
                r_surv       <= '0;
                case (r_item.op)
                    OP_ADD: begin
                        if (r_item.key_id == INVALID_KEY || r_item.name_code == '0) begin
                            r_res.status <= ST_INVALID;
                        end else if (r_found) begin
                            r_res.was_hit      <= 1'b1;
                            r_res.name_changed <= r_name[r_hit_slot] != r_item.name_code;
                            r_name[r_hit_slot]     <= r_item.name_code;
                            r_created[r_hit_slot]  <= r_item.now;
                            r_accessed[r_hit_slot] <= r_item.now;
                            r_res.name_out <= r_item.name_code;
                        end else if (r_free_ok) begin
                            r_valid[r_free_slot]    <= 1'b1;
                            r_key[r_free_slot]      <= r_item.key_id;
                            r_name[r_free_slot]     <= r_item.name_code;
                            r_created[r_free_slot]  <= r_item.now;
                            r_accessed[r_free_slot] <= r_item.now;
                            r_res.name_out <= r_item.name_code;
                        end else begin
                            r_res.status <= ST_FULL;
                        end
                    end
                    OP_LOOKUP: begin
                        if (r_item.key_id == INVALID_KEY) begin
                            r_res.status <= ST_INVALID;
                        end else if (r_found) begin
                            r_res.was_hit <= 1'b1;
                            r_hits <= r_hits + 32'd1;
                            if (r_item.now - r_created[r_hit_slot] >= {16'd0, i_ttl}) begin
                                if (r_item.name_code == '0) begin
                                    r_res.status <= ST_INVALID;
                                end else begin
                                    r_res.name_changed <=
                                        r_name[r_hit_slot] != r_item.name_code;
                                    r_name[r_hit_slot]     <= r_item.name_code;
                                    r_created[r_hit_slot]  <= r_item.now;
                                    r_accessed[r_hit_slot] <= r_item.now;
                                    r_res.name_out <= r_item.name_code;
                                    r_run_maint    <= 1'b1;
                                end
                            end else begin
                                r_accessed[r_hit_slot] <= r_item.now;
                                r_res.name_out <= r_name[r_hit_slot];
                                r_run_maint    <= 1'b1;
                            end
                        end else begin
                            r_misses <= r_misses + 32'd1;
                            if (r_item.name_code == '0) begin
                                r_res.status <= ST_INVALID;
                            end else if (r_free_ok) begin
                                r_valid[r_free_slot]    <= 1'b1;
                                r_key[r_free_slot]      <= r_item.key_id;
                                r_name[r_free_slot]     <= r_item.name_code;
                                r_created[r_free_slot]  <= r_item.now;
                                r_accessed[r_free_slot] <= r_item.now;
                                r_res.name_out <= r_item.name_code;
                                r_run_maint    <= 1'b1;
                            end else begin
                                r_res.status <= ST_FULL;
                            end
                        end
                    end
                    OP_CHECK: begin
                        if (r_item.now - r_last_check >= CHECK_INTERVAL) begin
                            r_res.maintained <= 1'b1;
                            r_last_check     <= r_item.now;
                            r_run_maint      <= 1'b1;
                        end
                    end
                    default: ;
                endcase
            end
            if (i_cmd.maint_step) begin
                if (r_valid[r_idx]) begin
                    if (age_created >= {16'd0, i_ttl}) begin
                        r_valid[r_idx] <= 1'b0;
                    end else begin
                        r_surv <= r_surv + 1'b1;
                        if (!r_victim_ok || age_access > r_victim_age) begin
                            r_victim_ok  <= 1'b1;
                            r_victim     <= r_idx;
                            r_victim_age <= age_access;
                        end
                    end
                end
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.evict) begin
                if (r_victim_ok && r_surv > CNT_W'(i_max)) r_valid[r_victim] <= 1'b0;
            end
            if (i_cmd.finish) begin
                r_res.entry_count <= 5'(cnt);
                r_res.hit_total   <= r_hits;
                r_res.miss_total  <= r_misses;
            end
        end
    end

endmodule

/* src/tlc_ctrl.sv */
`timescale 1ns / 1ps
module tlc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    output logic           o_busy,
    output logic           o_done,
    output tlc_pkg::t_cmd  o_cmd,
    input  tlc_pkg::t_stat i_stat
);
    import tlc_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_start) n_state = S_SEARCH;
            S_SEARCH: if (i_stat.scan_last) n_state = S_DECIDE;
            S_DECIDE: n_state = S_MAINT;
            S_MAINT: begin
                if (!i_stat.run_maint) n_state = S_DONE;
                else if (i_stat.scan_last) n_state = S_EVICT;
            end
            S_EVICT:  n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = r_state != S_IDLE;
        o_done = 1'b0;
        case (r_state)
            S_IDLE:   o_cmd.load = i_start;
            S_SEARCH: o_cmd.search_step = 1'b1;
            S_DECIDE: o_cmd.decide = 1'b1;
            S_MAINT:  o_cmd.maint_step = i_stat.run_maint;
            S_EVICT:  o_cmd.evict = 1'b1;
            S_DONE:   o_cmd.finish = 1'b1;
            default:  ;
        endcase
        o_done = (r_state == S_DONE);
    end

endmodule

/* src/ttl_lru_id_cache_unit.sv */
`timescale 1ns / 1ps
// TTL id cache with LRU eviction, 16 slots.
// Command channel: i_item is taken when start is high and busy is low.
// Each command yields exactly one result beat on o_res, flagged by o_valid
// for one cycle; the receiver cannot stall and must take it then.
// Sequence: a search scan over all slots, then a decide step; then, for
// lookups and checks that run maintenance, a maintenance scan over all slots
// and an evict step, otherwise a pass-through state; then a done state
// latches the result, and the beat appears the cycle after that.
// Busy stays high meanwhile and drops in the beat cycle, so a new command
// can be taken then. One command at a time.
// Config: i_cfg_we writes register i_cfg_addr (0 ttl, 1 max entries) at
// once; write only while busy is low and no beat is pending.
// Reset (sync, active low) clears all valid bits, counters, the last
// check time and reloads ttl 600, max entries 12.
module ttl_lru_id_cache_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  tlc_pkg::t_in  i_item,
    output logic          o_valid,
    output tlc_pkg::t_out o_res,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_addr,
    input  logic [15:0]   i_cfg_data
);
    import tlc_pkg::*;

    logic [15:0] r_ttl;
    logic [3:0]  r_max;
    logic        r_valid;
    logic        done;
    t_cmd        cmd;
    t_stat       stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ttl   <= 16'd600;
            r_max   <= 4'd12;
            r_valid <= 1'b0;
        end else begin
            r_valid <= done;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_TTL: r_ttl <= i_cfg_data;
                    REG_MAX: r_max <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
        end
    end

    assign o_valid = r_valid;

    tlc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (done),
        .o_cmd   (cmd),
        .i_stat  (stat)
    );

    tlc_datapath u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_item  (i_item),
        .i_ttl   (r_ttl),
        .i_max   (r_max),
        .o_res   (o_res)
    );

endmodule

/* tb/tlc_checker.sv */
`timescale 1ns / 1ps
module tlc_checker (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          busy,
    input  tlc_pkg::t_in  i_item,
    input  logic          o_valid,
    input  tlc_pkg::t_out o_res,
    input  logic          i_cfg_we,
    input  logic [0:0]    i_cfg_addr,
    input  logic [15:0]   i_cfg_data,
    output int            o_pending,
    output int            o_fails
);
    import tlc_pkg::*;

    logic [15:0] ttl;
    logic [3:0]  max_ent;
    logic        vld    [TABLE_DEPTH];
    logic [31:0] key    [TABLE_DEPTH];
    logic [63:0] name   [TABLE_DEPTH];
    logic [31:0] born   [TABLE_DEPTH];
    logic [31:0] touched[TABLE_DEPTH];
    logic [31:0] last_check;
    logic [31:0] hits;
    logic [31:0] misses;

    t_out result_q[$];
    int   fails;

    assign o_pending = result_q.size();
    assign o_fails   = fails;

    function automatic int slot_of(logic [31:0] k);
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (vld[i] && key[i] == k) return i;
        return -1;
    endfunction

    function automatic int free_slot();
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (!vld[i]) return i;
        return -1;
    endfunction

    function automatic logic [4:0] live_count();
        logic [4:0] n;
        n = 5'd0;
        for (int i = 0; i < TABLE_DEPTH; i++)
            if (vld[i]) n++;
        return n;
    endfunction

    function automatic void put(int s, logic [31:0] k, logic [63:0] nm, logic [31:0] t);
        vld[s] = 1'b1;
        key[s] = k;
        name[s] = nm;
        born[s] = t;
        touched[s] = t;
    endfunction

    // drop stale entries, then evict the least recently touched one if over limit
    function automatic void sweep(logic [31:0] t);
        int          victim;
        logic [31:0] vage;
        logic [31:0] a;
        victim = -1;
        vage = 0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            if (!vld[i]) continue;
            if (t - born[i] >= {16'd0, ttl}) begin
                vld[i] = 1'b0;
            end else begin
                a = t - touched[i];
                if (victim < 0 || a > vage) begin
                    victim = i;
                    vage = a;
                end
            end
        end
        if (victim >= 0 && live_count() > {1'b0, max_ent}) vld[victim] = 1'b0;
    endfunction

    function automatic t_out cache_step(t_in x);
        t_out r;
        int   s;
        r = '0;
        case (x.op)
            OP_ADD: begin
                if (x.key_id == INVALID_KEY || x.name_code == 0) begin
                    r.status = ST_INVALID;
                end else begin
                    s = slot_of(x.key_id);
                    if (s >= 0) begin
                        r.was_hit = 1'b1;
                        r.name_changed = (name[s] != x.name_code);
                        put(s, x.key_id, x.name_code, x.now);
                        r.name_out = x.name_code;
                    end else begin
                        s = free_slot();
                        if (s >= 0) begin
                            put(s, x.key_id, x.name_code, x.now);
                            r.name_out = x.name_code;
                        end else begin
                            r.status = ST_FULL;
                        end
                    end
                end
            end
            OP_LOOKUP: begin
                if (x.key_id == INVALID_KEY) begin
                    r.status = ST_INVALID;
                end else begin
                    s = slot_of(x.key_id);
                    if (s >= 0) begin
                        r.was_hit = 1'b1;
                        hits++;
                        if (x.now - born[s] >= {16'd0, ttl}) begin
                            if (x.name_code == 0) begin
                                r.status = ST_INVALID;
                            end else begin
                                r.name_changed = (name[s] != x.name_code);
                                put(s, x.key_id, x.name_code, x.now);
                            end
                        end else begin
                            touched[s] = x.now;
                        end
                        if (r.status == ST_OK) begin
                            r.name_out = name[s];
                            sweep(x.now);
                        end
                    end else begin
                        misses++;
                        if (x.name_code == 0) begin
                            r.status = ST_INVALID;
                        end else begin
                            s = free_slot();
                            if (s >= 0) begin
                                put(s, x.key_id, x.name_code, x.now);
                                r.name_out = x.name_code;
                                sweep(x.now);
                            end else begin
                                r.status = ST_FULL;
                            end
                        end
                    end
                end
            end
            OP_CHECK: begin
                if (x.now - last_check >= CHECK_INTERVAL) begin
                    r.maintained = 1'b1;
                    last_check = x.now;
                    sweep(x.now);
                end
            end
            default: ;
        endcase
        r.entry_count = live_count();
        r.hit_total = hits;
        r.miss_total = misses;
        return r;
    endfunction

    task automatic report(string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        fails++;
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        t_out e;
        if (!i_rst_n) begin
            ttl = 16'd600;
            max_ent = 4'd12;
            for (int i = 0; i < TABLE_DEPTH; i++) vld[i] = 1'b0;
            last_check = 0;
            hits = 0;
            misses = 0;
            result_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == REG_TTL) ttl = i_cfg_data;
                else max_ent = i_cfg_data[3:0];
            end
            if (o_valid) begin
                if (result_q.size() == 0) begin
                    report("result beat with nothing expected");
                end else begin
                    e = result_q.pop_front();
                    if (o_res.status !== e.status)
                        report($sformatf("status %0d exp %0d", o_res.status, e.status));
                    if (o_res.was_hit !== e.was_hit)
                        report($sformatf("was_hit %0b exp %0b", o_res.was_hit, e.was_hit));
                    if (o_res.name_out !== e.name_out)
                        report($sformatf("name_out %h exp %h", o_res.name_out, e.name_out));
                    if (o_res.name_changed !== e.name_changed)
                        report($sformatf("name_changed %0b exp %0b",
                                         o_res.name_changed, e.name_changed));
                    if (o_res.maintained !== e.maintained)
                        report($sformatf("maintained %0b exp %0b",
                                         o_res.maintained, e.maintained));
                    if (o_res.entry_count !== e.entry_count)
                        report($sformatf("entry_count %0d exp %0d",
                                         o_res.entry_count, e.entry_count));
                    if (o_res.hit_total !== e.hit_total)
                        report($sformatf("hit_total %0d exp %0d", o_res.hit_total, e.hit_total));
                    if (o_res.miss_total !== e.miss_total)
                        report($sformatf("miss_total %0d exp %0d",
                                         o_res.miss_total, e.miss_total));
                end
            end
            if (start && !busy) result_q.push_back(cache_step(i_item));
        end
    end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;
    import tlc_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    t_in         i_item = '0;
    logic        o_valid;
    t_out        o_res;
    logic        i_cfg_we = 1'b0;
    logic [0:0]  i_cfg_addr = REG_TTL;
    logic [15:0] i_cfg_data = '0;
    int          pending;
    int          fails;

    logic        busy_s = 1'b1;
    logic [31:0] key_pool[24];
    logic [63:0] name_pool[4];
    logic [31:0] clock_now;
    int          sent;
    int          phases;

    always #10 i_clk = ~i_clk;
    // busy only moves at rising edges; the falling-edge copy is stable at the next edge
    always @(negedge i_clk) busy_s = busy;

    ttl_lru_id_cache_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_res(o_res), .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data)
    );

    tlc_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_item(i_item),
        .o_valid(o_valid), .o_res(o_res), .i_cfg_we(i_cfg_we), .i_cfg_addr(i_cfg_addr),
        .i_cfg_data(i_cfg_data), .o_pending(pending), .o_fails(fails)
    );

    task automatic send(logic [1:0] op, logic [31:0] k, logic [63:0] nm,
                        logic [31:0] t, int gap);
        i_item <= '{op: op, key_id: k, name_code: nm, now: t};
        start <= 1'b1;
        do @(posedge i_clk); while (busy_s);
        sent++;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        // a beat may still be in flight for the last accepted command
        repeat (45) @(posedge i_clk);
    endtask

    task automatic set_regs(logic [15:0] ttl, logic [15:0] mx);
        drain();
        i_cfg_we <= 1'b1;
        i_cfg_addr <= REG_TTL;
        i_cfg_data <= ttl;
        @(posedge i_clk);
        i_cfg_addr <= REG_MAX;
        i_cfg_data <= mx;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        phases++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic random_beat();
        logic [1:0]  op;
        logic [31:0] k;
        logic [63:0] nm;
        int          r;
        r = $urandom_range(0, 99);
        op = (r < 35) ? OP_ADD : (r < 70) ? OP_LOOKUP : (r < 95) ? OP_CHECK : 2'd3;
        r = $urandom_range(0, 99);
        k = (r < 3) ? INVALID_KEY : (r < 8) ? $urandom() : key_pool[$urandom_range(0, 23)];
        r = $urandom_range(0, 99);
        nm = (r < 8) ? 64'd0 : (r < 60) ? name_pool[$urandom_range(0, 3)]
                                         : {$urandom(), $urandom()};
        r = $urandom_range(0, 99);
        if (r < 4) clock_now = $urandom();
        else if (r < 12) clock_now += $urandom_range(0, 1200);
        else clock_now += $urandom_range(0, 8);
        send(op, k, nm, clock_now, pick_gap());
    endtask

    initial begin
        logic [15:0] ttl_set[6] = '{16'd600, 16'd1, 16'd65535, 16'd0, 16'd40, 16'd65535};
        logic [15:0] max_set[6] = '{16'd12, 16'd4, 16'd15, 16'd0, 16'd8, 16'hFFF4};
        sent = 0;
        phases = 0;
        for (int i = 0; i < 24; i++) key_pool[i] = (i < 2) ? (i == 0 ? 32'd0 : 32'hFFFF_FFFE)
                                                            : $urandom();
        name_pool[0] = 64'd1;
        name_pool[1] = '1;
        name_pool[2] = {$urandom(), $urandom()};
        name_pool[3] = {$urandom(), $urandom()};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part under reset values
        send(OP_ADD, INVALID_KEY, 64'd5, 32'd10, 0);
        send(OP_ADD, 32'd7, 64'd0, 32'd10, 0);
        send(OP_ADD, 32'd0, '1, 32'd10, 1);
        send(OP_ADD, 32'd0, 64'd9, 32'd11, 0);
        send(OP_ADD, 32'd0, 64'd9, 32'd12, 0);
        send(OP_LOOKUP, INVALID_KEY, 64'd3, 32'd13, 0);
        send(OP_LOOKUP, 32'd55, 64'd0, 32'd14, 2);
        send(OP_LOOKUP, 32'd55, 64'd77, 32'd15, 0);
        send(OP_LOOKUP, 32'd0, 64'd1, 32'd16, 0);
        send(OP_LOOKUP, 32'd0, 64'd0, 32'd700, 0);
        send(OP_LOOKUP, 32'd0, 64'd4, 32'd701, 0);
        send(OP_CHECK, 32'd0, 64'd0, 32'd3, 0);
        send(OP_CHECK, 32'd0, 64'd0, 32'd702, 0);
        send(2'd3, 32'hFFFF_FFFE, '1, '1, 0);
        send(OP_LOOKUP, 32'd0, 64'd4, 32'd100, 0);
        for (int i = 0; i < 16; i++) send(OP_ADD, 32'h100 + i, 64'h200 + i, 32'd710, 0);
        send(OP_ADD, 32'h999, 64'd6, 32'd711, 0);
        send(OP_LOOKUP, 32'h998, 64'd6, 32'd712, 0);

        clock_now = 32'd720;
        for (int p = 0; p < 6; p++) begin
            set_regs(ttl_set[p], max_set[p]);
            for (int n = 0; n < 210; n++) begin
                if ($urandom_range(0, 59) == 0) drain();
                random_beat();
            end
        end
        drain();
        $display("Sent %0d commands over %0d register settings (ttl and limit extremes).",
                 sent, phases);
        if (fails == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #60ms;
        $display("Timeout with %0d beats outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
